// ----- src/imuoc_pkg.sv -----
// ----------------------------------------------------------------------------
// imuoc_pkg: shared types and constants of the IMU offset calibrator
// Widths, run constants, lane control struct and result status flags.
// ----------------------------------------------------------------------------
package imuoc_pkg;

  localparam int AXIS_W          = 16;
  localparam int NUM_AXES        = 3;
  localparam int AXIS_Z          = 2;
  localparam int ONE_G_W         = 15;
  localparam int SUM_W           = 25;
  localparam int MAG_W           = 24;
  localparam int CNT_W           = 8;
  localparam int CAL_SAMPLES_DEF = 200;
  localparam int DATA_W          = 2 * NUM_AXES * AXIS_W;
  localparam int CMD_W           = 2;
  localparam int DIV_LAT         = 4;
  localparam int DIV_CNT_W       = 3;

  localparam logic [ONE_G_W-1:0] ONE_G_RESET = 15'd8196;

  // cmd bit positions
  localparam int CMD_GYRO_BIT  = 0;
  localparam int CMD_ACCEL_BIT = 1;

  typedef enum logic [1:0] {
    SUM_HOLD,
    SUM_CLEAR,
    SUM_GYRO,
    SUM_ACCEL
  } sum_op_t;

  typedef struct packed {
    logic    clr_gyro;
    logic    clr_accel;
    sum_op_t sum_op;
    logic    div_start;
    logic    div_gyro;
    logic    wr_off;
  } lane_ctrl_t;

  // packed lowest bit last: gyro_busy is bit 0
  typedef struct packed {
    logic offsets_updated;
    logic accel_busy;
    logic gyro_busy;
  } status_t;

  localparam int STATUS_W = $bits(status_t);

endpackage

// ----- src/imuoc_ctrl.sv -----
// ----------------------------------------------------------------------------
// imuoc_ctrl: calibration run sequencer
// Tracks pending runs and the sample count, steers the axis lanes and
// holds off input while the lanes divide the finished sums.
// ----------------------------------------------------------------------------
module imuoc_ctrl
  import imuoc_pkg::*;
#(
  parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [CMD_W-1:0] cmd,
  output logic             idle,
  output lane_ctrl_t       lane_ctrl,
  output status_t          status
);

  localparam logic [CNT_W-1:0] LAST_COUNT  = CNT_W'(CAL_SAMPLES);
  localparam logic [CNT_W-1:0] FIRST_NEXT  = CNT_W'(2);

  logic                 gyro_pending;
  logic                 accel_pending;
  logic [CNT_W-1:0]     sample_count;
  logic [DIV_CNT_W-1:0] busy_cnt;

  logic             gp1, gp2, ap1, ap2, ap3;
  logic [CNT_W-1:0] sc1, sc2, sc3;
  logic             fin_g, fin_a;
  lane_ctrl_t       step;

  always_comb begin
    gp1   = gyro_pending;
    sc1   = sample_count;
    step  = '0;
    step.sum_op = SUM_HOLD;
    fin_g = 1'b0;
    fin_a = 1'b0;

    // a gyro start restarts the shared count, abandoning any accel run
    if (cmd[CMD_GYRO_BIT] && !gyro_pending) begin
      gp1 = 1'b1;
      sc1 = '0;
    end
    ap1 = accel_pending | cmd[CMD_ACCEL_BIT];

    sc2 = sc1;
    gp2 = gp1;
    ap2 = ap1;
    if (gp1) begin
      if (sc1 == '0) begin
        step.clr_gyro = 1'b1;
        step.sum_op   = SUM_CLEAR;
        sc2           = FIRST_NEXT;
      end else if (sc1 >= LAST_COUNT) begin
        fin_g          = 1'b1;
        step.div_start = 1'b1;
        step.div_gyro  = 1'b1;
        sc2            = '0;
        gp2            = 1'b0;
        ap2            = 1'b1;
      end else begin
        step.sum_op = SUM_GYRO;
        sc2         = CNT_W'(sc1 + 1'b1);
      end
    end

    sc3 = sc2;
    ap3 = ap2;
    if (ap2 && !gp2) begin
      if (sc2 == '0) begin
        step.clr_accel = 1'b1;
        step.sum_op    = SUM_CLEAR;
        sc3            = FIRST_NEXT;
      end else if (sc2 >= LAST_COUNT) begin
        fin_a          = 1'b1;
        step.div_start = 1'b1;
        step.div_gyro  = 1'b0;
        sc3            = '0;
        ap3            = 1'b0;
      end else begin
        step.sum_op = SUM_ACCEL;
        sc3         = CNT_W'(sc2 + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_pending  <= 1'b0;
      accel_pending <= 1'b0;
      sample_count  <= '0;
      busy_cnt      <= '0;
    end else begin
      if (accept) begin
        gyro_pending  <= gp2;
        accel_pending <= ap3;
        sample_count  <= sc3;
      end
      if (accept && (fin_g || fin_a)) begin
        busy_cnt <= DIV_CNT_W'(DIV_LAT);
      end else if (busy_cnt != '0) begin
        busy_cnt <= busy_cnt - 1'b1;
      end
    end
  end

  always_comb begin
    lane_ctrl           = '0;
    lane_ctrl.sum_op    = accept ? step.sum_op : SUM_HOLD;
    lane_ctrl.clr_gyro  = accept & step.clr_gyro;
    lane_ctrl.clr_accel = accept & step.clr_accel;
    lane_ctrl.div_start = accept & step.div_start;
    lane_ctrl.div_gyro  = step.div_gyro;
    // product is ready in the last divide cycle
    lane_ctrl.wr_off    = (busy_cnt == DIV_CNT_W'(1));
  end

  assign idle                   = (busy_cnt == '0);
  assign status.gyro_busy       = gp2;
  assign status.accel_busy      = ap3;
  assign status.offsets_updated = fin_g | fin_a;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    sample_count <= LAST_COUNT)
    else $error("sample count ran past the run length");

  a_div_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && (fin_g || fin_a)) |=> (busy_cnt == DIV_CNT_W'(DIV_LAT)) && !idle)
    else $error("input not held off after a run finished");

  a_gyro_hands_off: assert property (@(posedge clk) disable iff (rst)
    (accept && fin_g) |=> accel_pending && !gyro_pending)
    else $error("finished gyro run did not start accel run");

endmodule

// ----- src/imuoc_lane.sv -----
// ----------------------------------------------------------------------------
// imuoc_lane: one axis of the calibrator
// Holds the accel and gyro offsets and the running sum of one axis,
// corrects the incoming words and divides the finished sum by the run length.
// ----------------------------------------------------------------------------
module imuoc_lane
  import imuoc_pkg::*;
#(
  parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  lane_ctrl_t         lane_ctrl,
  input  logic [AXIS_W-1:0]  accel_raw,
  input  logic [AXIS_W-1:0]  gyro_raw,
  input  logic [ONE_G_W-1:0] bias,
  output logic [AXIS_W-1:0]  accel_corr,
  output logic [AXIS_W-1:0]  gyro_corr
);

  // exact reciprocal for numerators below 2**MAG_W
  localparam int          SHIFT      = MAG_W + $clog2(CAL_SAMPLES);
  localparam logic [63:0] RECIP_FULL = ((64'd1 << SHIFT) + CAL_SAMPLES - 1) / CAL_SAMPLES;
  localparam logic [MAG_W:0] RECIP   = RECIP_FULL[MAG_W:0];
  localparam int          PROD_W     = 2 * MAG_W + 1;

  logic [AXIS_W-1:0] accel_off;
  logic [AXIS_W-1:0] gyro_off;
  logic [SUM_W-1:0]  axis_sum;
  logic [SUM_W-1:0]  add_g;
  logic [SUM_W-1:0]  add_a;

  logic [SUM_W-1:0]  div_num;
  logic              div_to_gyro;
  logic [SUM_W-1:0]  num_neg;
  logic [MAG_W-1:0]  mag;
  logic              neg;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] prod_sh;
  logic [AXIS_W-1:0] quot;
  logic [AXIS_W-1:0] new_off;

  assign accel_corr = accel_raw - accel_off;
  assign gyro_corr  = gyro_raw - gyro_off;

  assign add_g = axis_sum + {{(SUM_W-AXIS_W){gyro_raw[AXIS_W-1]}}, gyro_raw};
  assign add_a = axis_sum + {{(SUM_W-AXIS_W){accel_raw[AXIS_W-1]}}, accel_raw}
               - {{(SUM_W-ONE_G_W){1'b0}}, bias};

  assign num_neg = -div_num;
  assign prod_sh = prod >> SHIFT;
  assign quot    = prod_sh[AXIS_W-1:0];
  assign new_off = neg ? -quot : quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_sum  <= '0;
      accel_off <= '0;
      gyro_off  <= '0;
    end else begin
      unique case (lane_ctrl.sum_op)
        SUM_HOLD:  axis_sum <= axis_sum;
        SUM_CLEAR: axis_sum <= '0;
        SUM_GYRO:  axis_sum <= add_g;
        SUM_ACCEL: axis_sum <= add_a;
      endcase
      if (lane_ctrl.clr_gyro) begin
        gyro_off <= '0;
      end else if (lane_ctrl.wr_off && div_to_gyro) begin
        gyro_off <= new_off;
      end
      if (lane_ctrl.clr_accel) begin
        accel_off <= '0;
      end else if (lane_ctrl.wr_off && !div_to_gyro) begin
        accel_off <= new_off;
      end
    end
  end

  // divide: capture sum, take magnitude, multiply by reciprocal, shift
  always_ff @(posedge clk) begin
    if (lane_ctrl.div_start) begin
      div_num     <= lane_ctrl.div_gyro ? add_g : add_a;
      div_to_gyro <= lane_ctrl.div_gyro;
    end
    neg  <= div_num[SUM_W-1];
    mag  <= div_num[SUM_W-1] ? num_neg[MAG_W-1:0] : div_num[MAG_W-1:0];
    prod <= PROD_W'(mag * RECIP);
  end

endmodule

// ----- src/imuoc_merge.sv -----
// ----------------------------------------------------------------------------
// imuoc_merge: result assembly and output buffer
// Packs the corrected words of all lanes with the run status into one
// result word and holds up to two of them for the output side.
// ----------------------------------------------------------------------------
module imuoc_merge
  import imuoc_pkg::*;
(
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  logic [NUM_AXES-1:0][AXIS_W-1:0]  accel_corr,
  input  logic [NUM_AXES-1:0][AXIS_W-1:0]  gyro_corr,
  input  status_t                          status,
  output logic                             space,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [DATA_W-1:0]                m_tdata,
  output logic [STATUS_W-1:0]              m_tuser
);

  typedef struct packed {
    status_t             st;
    logic [DATA_W-1:0]   data;
  } out_word_t;

  out_word_t  slot [2];
  out_word_t  word_in;
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  logic       pop;

  assign word_in.st   = status;
  assign word_in.data = {gyro_corr, accel_corr};

  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (count != 2'd0);
  assign space    = (count != 2'd2);
  assign m_tdata  = slot[rd_ptr].data;
  assign m_tuser  = slot[rd_ptr].st;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= word_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != 2'd2) || pop)
    else $error("result word pushed into a full buffer");

endmodule

// ----- src/imu_offset_calibrator.sv -----
// ----------------------------------------------------------------------------
// imu_offset_calibrator: six-axis bias removal with calibration by averaging
// Three axis lanes correct accel and gyro words and average calibration
// runs; a sequencer steers the runs and a merge stage buffers the results.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  s_        in   s_tvalid/s_tready    s_tdata: 6 raw axes, s_tuser: cmd
//  m_        out  m_tvalid/m_tready    m_tdata: 6 corrected axes, m_tuser: flags
//  cfg_      in   cfg_valid/cfg_ready  cfg_data: accel_one_g
//
// One word per cycle unless input is held off; each input word gives one result word.
// The word that finishes a calibration run holds off input
// while the lanes' reciprocal multipliers form the new offsets.
// Two result words are buffered, so input keeps flowing while one waits.
// Reset is synchronous: offsets clear, runs idle, accel_one_g returns to 8196.
// ----------------------------------------------------------------------------
module imu_offset_calibrator
  import imuoc_pkg::*;
#(
  parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z (16 bits each, low first)
  input  logic [DATA_W-1:0]   s_tdata,
  // cmd
  input  logic [CMD_W-1:0]    s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // accel_x_corr .. accel_z_corr, gyro_x_corr .. gyro_z_corr (16 bits, low first)
  output logic [DATA_W-1:0]   m_tdata,
  // gyro_busy, accel_busy, offsets_updated (low first)
  output logic [STATUS_W-1:0] m_tuser,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [ONE_G_W-1:0]  cfg_data
);

  logic [ONE_G_W-1:0]              accel_one_g;
  logic                            accept;
  logic                            idle;
  logic                            space;
  lane_ctrl_t                      lane_ctrl;
  status_t                         status;
  logic [NUM_AXES-1:0][AXIS_W-1:0] accel_corr;
  logic [NUM_AXES-1:0][AXIS_W-1:0] gyro_corr;

  assign cfg_ready = 1'b1;
  assign s_tready  = idle && space;
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_one_g <= ONE_G_RESET;
    end else if (cfg_valid && cfg_ready) begin
      accel_one_g <= cfg_data;
    end
  end

  imuoc_ctrl #(
    .CAL_SAMPLES(CAL_SAMPLES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .cmd      (s_tuser),
    .idle     (idle),
    .lane_ctrl(lane_ctrl),
    .status   (status)
  );

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
    // only the Z lane removes one g
    imuoc_lane #(
      .CAL_SAMPLES(CAL_SAMPLES)
    ) u_lane (
      .clk       (clk),
      .rst       (rst),
      .lane_ctrl (lane_ctrl),
      .accel_raw (s_tdata[AXIS_W*i +: AXIS_W]),
      .gyro_raw  (s_tdata[AXIS_W*(NUM_AXES+i) +: AXIS_W]),
      .bias      ((i == AXIS_Z) ? accel_one_g : {ONE_G_W{1'b0}}),
      .accel_corr(accel_corr[i]),
      .gyro_corr (gyro_corr[i])
    );
  end

  imuoc_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .accel_corr(accel_corr),
    .gyro_corr (gyro_corr),
    .status    (status),
    .space     (space),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

// ----- tb/sv/tb_imu_offset_calibrator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_imu_offset_calibrator: stream-level check of the IMU offset calibrator
// A table of directed words covers the field extremes and every command
// corner, then full calibration runs and command noise follow with random
// data. Each accepted input word advances a local model of the offsets and
// runs, and each result word is compared field by field with its prediction.
// ----------------------------------------------------------------------------
module tb_imu_offset_calibrator;
  import imuoc_pkg::*;

  localparam int CAL_N       = CAL_SAMPLES_DEF;
  localparam int DIR_N       = 14;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_AT     = 150;
  localparam int HOLD_CYCLES = 60;
  localparam int SETTLE      = DIV_LAT + 4;

  typedef enum logic [CMD_W-1:0] {
    OP_SAMPLE,
    OP_GYRO_CAL,
    OP_ACCEL_CAL,
    OP_BOTH_CAL
  } cal_cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    status_t           flags;
  } cal_result_t;

  typedef struct packed {
    cal_cmd_t          cmd;
    logic [DATA_W-1:0] raw;
    logic              typed;
    logic [DATA_W-1:0] exp_data;
    status_t           exp_flags;
  } dir_row_t;

  localparam status_t ST_IDLE  = '0;
  localparam status_t ST_ACCEL = '{offsets_updated: 1'b0, accel_busy: 1'b1, gyro_busy: 1'b0};

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [DATA_W-1:0]   s_tdata   = '0;
  logic [CMD_W-1:0]    s_tuser   = OP_SAMPLE;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [DATA_W-1:0]   m_tdata;
  logic [STATUS_W-1:0] m_tuser;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [ONE_G_W-1:0]  cfg_data  = '0;

  // model of the offsets and the calibration runs
  logic [AXIS_W-1:0] acc_off [NUM_AXES];
  logic [AXIS_W-1:0] gyr_off [NUM_AXES];
  int                run_sum [NUM_AXES];
  int                run_count  = 0;
  bit                gyro_pend  = 1'b0;
  bit                accel_pend = 1'b0;
  int                one_g      = ONE_G_RESET;

  cal_result_t corr_due [$];
  dir_row_t    dir_rows [DIR_N];

  // side information for directed words with a hand-written result
  logic              row_typed = 1'b0;
  logic [DATA_W-1:0] row_data  = '0;
  status_t           row_flags = ST_IDLE;

  bit          pin_mode = 1'b0;
  logic [5:0]  pin_sign = '0;
  int          sent_count = 0;
  int          got_count  = 0;
  int          fail_count = 0;
  int          quiet      = 0;
  bit          moved;
  int          mi;
  cal_result_t new_exp, seen_exp;
  logic [STATUS_W-1:0] exp_bits;

  string axis_names [2*NUM_AXES] = '{"accel_x_corr", "accel_y_corr", "accel_z_corr",
                                     "gyro_x_corr", "gyro_y_corr", "gyro_z_corr"};
  string flag_names [STATUS_W] = '{"gyro_busy", "accel_busy", "offsets_updated"};

  initial begin
    for (int i = 0; i < NUM_AXES; i++) begin
      acc_off[i] = '0;
      gyr_off[i] = '0;
      run_sum[i] = 0;
    end
  end

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  imu_offset_calibrator #(
    .CAL_SAMPLES(CAL_N)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  function automatic logic [DATA_W-1:0] pack6(logic [AXIS_W-1:0] ax, logic [AXIS_W-1:0] ay,
                                              logic [AXIS_W-1:0] az, logic [AXIS_W-1:0] gx,
                                              logic [AXIS_W-1:0] gy, logic [AXIS_W-1:0] gz);
    return {gz, gy, gx, az, ay, ax};
  endfunction

  // Pinned mode pushes most axes to a full-scale value so the run sums get large.
  function automatic logic [DATA_W-1:0] draw_sample();
    logic [DATA_W-1:0] w;
    logic [AXIS_W-1:0] v;
    for (int i = 0; i < 2*NUM_AXES; i++) begin
      if (pin_mode && $urandom_range(0, 3) != 0) begin
        v = pin_sign[i] ? 16'h7FFF : 16'h8000;
      end else begin
        v = AXIS_W'($urandom);
      end
      w[AXIS_W*i +: AXIS_W] = v;
    end
    return w;
  endfunction

  // One sample of a calibration run; returns 1 when the run closes.
  function automatic bit accumulate_bias(bit on_accel, int v0, int v1, int v2);
    int q;
    if (run_count == 0) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        if (on_accel) acc_off[i] = '0;
        else gyr_off[i] = '0;
        run_sum[i] = 0;
      end
      run_count = 2;
      return 1'b0;
    end
    run_sum[0] += v0;
    run_sum[1] += v1;
    run_sum[2] += v2;
    if (run_count >= CAL_N) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        q = run_sum[i] / CAL_N;
        if (on_accel) acc_off[i] = q[AXIS_W-1:0];
        else gyr_off[i] = q[AXIS_W-1:0];
      end
      run_count = 0;
      return 1'b1;
    end
    run_count = (run_count + 1) & ((1 << CNT_W) - 1);
    return 1'b0;
  endfunction

  function automatic cal_result_t predict_corrected(logic [CMD_W-1:0] cmd,
                                                    logic [DATA_W-1:0] raw);
    cal_result_t r;
    int          a [NUM_AXES];
    int          g [NUM_AXES];
    logic        upd;
    upd = 1'b0;
    // correct with the offsets held before this word
    for (int i = 0; i < NUM_AXES; i++) begin
      a[i] = $signed(raw[AXIS_W*i +: AXIS_W]);
      g[i] = $signed(raw[AXIS_W*(i+NUM_AXES) +: AXIS_W]);
      r.data[AXIS_W*i +: AXIS_W] = raw[AXIS_W*i +: AXIS_W] - acc_off[i];
      r.data[AXIS_W*(i+NUM_AXES) +: AXIS_W] = raw[AXIS_W*(i+NUM_AXES) +: AXIS_W] - gyr_off[i];
    end
    if (cmd[CMD_GYRO_BIT] && !gyro_pend) begin
      gyro_pend = 1'b1;
      run_count = 0;
    end
    if (cmd[CMD_ACCEL_BIT]) accel_pend = 1'b1;
    if (gyro_pend && accumulate_bias(1'b0, g[0], g[1], g[2])) begin
      gyro_pend  = 1'b0;
      accel_pend = 1'b1;
      upd        = 1'b1;
    end
    if (accel_pend && !gyro_pend && accumulate_bias(1'b1, a[0], a[1], a[2] - one_g)) begin
      accel_pend = 1'b0;
      upd        = 1'b1;
    end
    r.flags.gyro_busy       = gyro_pend;
    r.flags.accel_busy      = accel_pend;
    r.flags.offsets_updated = upd;
    return r;
  endfunction

  // Predict on input words, check result words, watch for a hang.
  always @(posedge clk) begin
    if (!rst) begin
      moved = 1'b0;
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        one_g = cfg_data;
      end
      if (s_tvalid && s_tready) begin
        moved   = 1'b1;
        new_exp = predict_corrected(s_tuser, s_tdata);
        if (row_typed) begin
          new_exp.data  = row_data;
          new_exp.flags = row_flags;
        end
        corr_due.push_back(new_exp);
      end
      if (m_tvalid && m_tready) begin
        moved = 1'b1;
        if (corr_due.size() == 0) begin
          $error("result word with nothing expected: data %h user %h", m_tdata, m_tuser);
          fail_count++;
        end else begin
          seen_exp = corr_due.pop_front();
          exp_bits = seen_exp.flags;
          for (mi = 0; mi < 2*NUM_AXES; mi++) begin
            if (seen_exp.data[AXIS_W*mi +: AXIS_W] !== m_tdata[AXIS_W*mi +: AXIS_W]) begin
              $error("%s: expected %h, got %h", axis_names[mi],
                     seen_exp.data[AXIS_W*mi +: AXIS_W], m_tdata[AXIS_W*mi +: AXIS_W]);
              fail_count++;
            end
          end
          for (mi = 0; mi < STATUS_W; mi++) begin
            if (exp_bits[mi] !== m_tuser[mi]) begin
              $error("%s: expected %b, got %b", flag_names[mi], exp_bits[mi], m_tuser[mi]);
              fail_count++;
            end
          end
        end
      end
      quiet = moved ? 0 : quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("tb_imu_offset_calibrator NOT OK");
        $finish;
      end
    end
  end

  // Result sink: random stalls, stretches without stalls, one long hold-off.
  initial begin : result_sink
    int stall;
    while (rst) @(negedge clk);
    forever begin
      if (got_count == HOLD_AT) stall = HOLD_CYCLES;
      else if ((got_count / 29) % 4 == 1) stall = 0;
      else stall = $urandom_range(0, 13);
      @(negedge clk);
      if (stall > 0) begin
        m_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got_count++;
    end
  end

  task automatic send_word(cal_cmd_t cmd, logic [DATA_W-1:0] raw, logic typed,
                           logic [DATA_W-1:0] t_data, status_t t_flags);
    int gap;
    gap = ((sent_count / 37) % 3 == 2) ? 0 : $urandom_range(0, 13);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid  = 1'b1;
    s_tuser   = cmd;
    s_tdata   = raw;
    row_typed = typed;
    row_data  = t_data;
    row_flags = t_flags;
    do @(posedge clk); while (!s_tready);
    sent_count++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (corr_due.size() != 0) @(negedge clk);
  endtask

  // Write accel_one_g with the block idle; let a closing division settle first.
  task automatic write_one_g(logic [ONE_G_W-1:0] value);
    drain_results();
    repeat (SETTLE) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin : stimulus
    cal_cmd_t op;
    // offsets are zero after reset, so the first rows pass the raw words through
    dir_rows[0]  = '{OP_SAMPLE, pack6(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF),
                     1'b1, pack6(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF),
                     ST_IDLE};
    dir_rows[1]  = '{OP_SAMPLE, pack6(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000),
                     1'b1, pack6(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000),
                     ST_IDLE};
    dir_rows[2]  = '{OP_SAMPLE, pack6(16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE, 16'h5555, 16'hAAAA),
                     1'b1, pack6(16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE, 16'h5555, 16'hAAAA),
                     ST_IDLE};
    // accel start: this word is the run's first and only clears offsets
    dir_rows[3]  = '{OP_ACCEL_CAL, pack6(16'h1234, 16'h8001, 16'h7FFE, 16'h0F0F, 16'hF0F0, 16'h00FF),
                     1'b1, pack6(16'h1234, 16'h8001, 16'h7FFE, 16'h0F0F, 16'hF0F0, 16'h00FF),
                     ST_ACCEL};
    dir_rows[4]  = '{OP_SAMPLE, pack6(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0001, 16'h8000, 16'hFFFF),
                     1'b0, '0, ST_IDLE};
    // accel start while accel pending: ignored
    dir_rows[5]  = '{OP_ACCEL_CAL, pack6(16'h8000, 16'h8000, 16'h8000, 16'h4000, 16'hC000, 16'h2000),
                     1'b0, '0, ST_IDLE};
    dir_rows[6]  = '{OP_SAMPLE, pack6(16'h0100, 16'hFF00, 16'h2004, 16'h0003, 16'hFFFD, 16'h0000),
                     1'b0, '0, ST_IDLE};
    // gyro start drops the accel run in progress
    dir_rows[7]  = '{OP_GYRO_CAL, pack6(16'h0010, 16'hFFF0, 16'h2100, 16'h7FFF, 16'h8000, 16'h0042),
                     1'b0, '0, ST_IDLE};
    dir_rows[8]  = '{OP_GYRO_CAL, pack6(16'hABCD, 16'h5432, 16'h1FFF, 16'h8000, 16'h7FFF, 16'hFFBE),
                     1'b0, '0, ST_IDLE};
    dir_rows[9]  = '{OP_BOTH_CAL, pack6(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000),
                     1'b0, '0, ST_IDLE};
    dir_rows[10] = '{OP_ACCEL_CAL, pack6(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000),
                     1'b0, '0, ST_IDLE};
    dir_rows[11] = '{OP_SAMPLE, pack6(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF),
                     1'b0, '0, ST_IDLE};
    dir_rows[12] = '{OP_SAMPLE, pack6(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000),
                     1'b0, '0, ST_IDLE};
    dir_rows[13] = '{OP_SAMPLE, pack6(16'hFFFF, 16'h0001, 16'h8001, 16'h7FFE, 16'hFFFF, 16'h0001),
                     1'b0, '0, ST_IDLE};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int k = 0; k < DIR_N; k++) begin
      send_word(dir_rows[k].cmd, dir_rows[k].raw, dir_rows[k].typed, dir_rows[k].exp_data,
                dir_rows[k].exp_flags);
    end

    // let the gyro run close, hand over to accel and close that run too
    write_one_g({ONE_G_W{1'b1}});
    pin_mode = 1'b1;
    pin_sign = 6'($urandom);
    for (int k = 0; k < 400; k++) begin
      op = ($urandom_range(0, 29) == 0) ? OP_ACCEL_CAL : OP_SAMPLE;
      send_word(op, draw_sample(), 1'b0, '0, ST_IDLE);
    end

    // command noise: restarts, drops and ignored starts
    write_one_g('0);
    pin_mode = 1'b0;
    for (int k = 0; k < 25; k++) begin
      op = ($urandom_range(0, 3) == 0) ? cal_cmd_t'($urandom_range(1, 3)) : OP_SAMPLE;
      send_word(op, draw_sample(), 1'b0, '0, ST_IDLE);
    end

    write_one_g(ONE_G_W'($urandom_range(1, 32766)));
    pin_mode = 1'b1;
    pin_sign = 6'($urandom);
    for (int k = 0; k < 25; k++) begin
      if (k == 15) drain_results();
      op = cal_cmd_t'($urandom_range(0, 3));
      send_word(op, draw_sample(), 1'b0, '0, ST_IDLE);
    end

    drain_results();
    repeat (DIV_LAT + 16) @(negedge clk);
    if (fail_count == 0 && corr_due.size() == 0) begin
      $display("tb_imu_offset_calibrator OK");
    end else begin
      $display("tb_imu_offset_calibrator NOT OK");
    end
    $finish;
  end

endmodule

// ----- imu_offset_calibrator.f -----
src/imuoc_pkg.sv
src/imuoc_ctrl.sv
src/imuoc_lane.sv
src/imuoc_merge.sv
src/imu_offset_calibrator.sv
tb/sv/tb_imu_offset_calibrator.sv
